>>> src/rmst_pkg.sv
package rmst_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 10;
  localparam int SIZE_DEFAULT = 1024;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_QUERY
  } seq_state_t;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] max_value;
    logic                     range_error;
  } result_t;

  function automatic logic signed [DATA_W-1:0] smax(
    input logic signed [DATA_W-1:0] x,
    input logic signed [DATA_W-1:0] y
  );
    smax = (x >= y) ? x : y;
  endfunction

endpackage

>>> src/rmst_mem.sv
module rmst_mem #(
  parameter int DEPTH = 2 * rmst_pkg::SIZE_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [rmst_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                    raddr,
  output logic signed [rmst_pkg::DATA_W-1:0] rdata
);
  import rmst_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/rmst_seq.sv
module rmst_seq #(
  parameter int SIZE = rmst_pkg::SIZE_DEFAULT,
  parameter int AW   = $clog2(2 * SIZE)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               req_type,
  input  logic [rmst_pkg::POS_W-1:0]         position,
  input  logic signed [rmst_pkg::DATA_W-1:0] new_value,
  input  logic [rmst_pkg::POS_W-1:0]         range_low,
  input  logic [rmst_pkg::POS_W-1:0]         range_high,
  output logic                               mem_we,
  output logic [AW-1:0]                      mem_waddr,
  output logic signed [rmst_pkg::DATA_W-1:0] mem_wdata,
  output logic [AW-1:0]                      mem_raddr,
  input  logic signed [rmst_pkg::DATA_W-1:0] mem_rdata,
  output rmst_pkg::result_t                  res
);
  import rmst_pkg::*;

  localparam int NW = AW + 1;
  localparam logic [NW-1:0] SIZE_N   = NW'(SIZE);
  localparam logic [31:0]   SIZE_W   = 32'(SIZE);
  localparam logic [AW-1:0] LAST_NODE = AW'(2 * SIZE - 1);
  localparam logic [AW-1:0] ROOT     = AW'(1);
  localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

  seq_state_t               state, state_next;
  logic [AW-1:0]            clr_addr, clr_addr_next;
  logic [AW-1:0]            node, node_next;
  logic signed [DATA_W-1:0] cur, cur_next;
  logic [NW-1:0]            a, a_next;
  logic [NW-1:0]            b, b_next;
  logic signed [DATA_W-1:0] best, best_next;
  logic                     pend, pend_next;

  logic [NW-1:0]            leaf;
  logic [AW-1:0]            parent;
  logic signed [DATA_W-1:0] up_max;
  logic signed [DATA_W-1:0] best_eff;
  logic                     pos_ok;
  logic                     q_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      pend     <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    node <= node_next;
    cur  <= cur_next;
    a    <= a_next;
    b    <= b_next;
    best <= best_next;
  end

  assign leaf     = NW'(position) + SIZE_N;
  assign parent   = node >> 1;
  assign up_max   = smax(cur, mem_rdata);
  // A node read issued last cycle is folded in as soon as its data arrives.
  assign best_eff = pend ? smax(best, mem_rdata) : best;
  assign pos_ok   = {{(32-POS_W){1'b0}}, position} < SIZE_W;
  assign q_err    = (range_low > range_high) ||
                    ({{(32-POS_W){1'b0}}, range_high} >= SIZE_W);
  assign busy     = (state != ST_IDLE);

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    node_next     = node;
    cur_next      = cur;
    a_next        = a;
    b_next        = b;
    best_next     = best;
    pend_next     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    res           = '0;

    unique case (state)
      ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_NODE) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_UPDATE) begin
            if (pos_ok) begin
              mem_we     = 1'b1;
              mem_waddr  = leaf[AW-1:0];
              mem_wdata  = new_value;
              mem_raddr  = leaf[AW-1:0] ^ AW'(1);
              node_next  = leaf[AW-1:0];
              cur_next   = new_value;
              state_next = ST_UPDATE;
            end
          end else if (q_err) begin
            res.valid       = 1'b1;
            res.range_error = 1'b1;
          end else begin
            a_next     = NW'(range_low) + SIZE_N;
            b_next     = NW'(range_high) + SIZE_N + NW'(1);
            best_next  = MIN_VAL;
            state_next = ST_QUERY;
          end
        end
      end

      ST_UPDATE: begin
        // The sibling of the current node is in mem_rdata; the parent's
        // sibling is fetched in the same cycle, so one level per cycle.
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_max;
        mem_raddr = parent ^ AW'(1);
        cur_next  = up_max;
        node_next = parent;
        if (parent == ROOT) begin
          state_next = ST_IDLE;
        end
      end

      ST_QUERY: begin
        best_next = best_eff;
        if (a >= b) begin
          res.valid     = 1'b1;
          res.max_value = best_eff;
          state_next    = ST_IDLE;
        end else if (a[0]) begin
          mem_raddr = a[AW-1:0];
          a_next    = a + NW'(1);
          pend_next = 1'b1;
        end else if (b[0]) begin
          mem_raddr = AW'(b - NW'(1));
          b_next    = b - NW'(1);
          pend_next = 1'b1;
        end else begin
          a_next = a >> 1;
          b_next = b >> 1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/range_max_segment_tree.sv
// Range-maximum segment tree over SIZE signed 32-bit entries.
// A request is taken on a rising edge with start high and busy low.
// req_type selects a point update (position, new_value) or a range
// maximum query over range_low..range_high, inclusive.
// An update gives no result. Its leaf is written in the accept cycle and
// each ancestor in turn after it, up to the root, with busy held high
// until the root is written.
// A query walks the tree from both ends, reading one node or shifting up
// one level at a time; done pulses for one cycle after the walk with
// max_value and range_error. A query that is empty or out of bounds gets
// range_error set and max_value zero, in the cycle after it is accepted.
// The tree memory has one write port and one registered read port.
// The receiver cannot stall: every result is shown for exactly one cycle.
// After reset the block clears all 2*SIZE tree nodes (2048 at the default
// size), one node per cycle, with busy held high.
module range_max_segment_tree #(
  parameter int SIZE = rmst_pkg::SIZE_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               req_type,
  input  logic [rmst_pkg::POS_W-1:0]         position,
  input  logic signed [rmst_pkg::DATA_W-1:0] new_value,
  input  logic [rmst_pkg::POS_W-1:0]         range_low,
  input  logic [rmst_pkg::POS_W-1:0]         range_high,
  output logic                               done,
  output logic signed [rmst_pkg::DATA_W-1:0] max_value,
  output logic                               range_error
);
  import rmst_pkg::*;

  localparam int DEPTH = 2 * SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;
  result_t                  res;

  rmst_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rmst_seq #(
    .SIZE (SIZE),
    .AW   (AW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .position   (position),
    .new_value  (new_value),
    .range_low  (range_low),
    .range_high (range_high),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    max_value   <= res.max_value;
    range_error <= res.range_error;
  end

endmodule
